/* design/sps_pkg.sv */
package sps_pkg;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 32;

    // fixed field and register widths
    localparam int LINE_WIDTH_BITS = 13;
    localparam int LINE_COUNT_BITS = 16;
    localparam int ROW_BITS        = 16;
    localparam int OUT_COL_BITS    = 12;
    localparam int CFG_DATA_BITS   = 16;

    // register reset values and lower limit of both sizes
    localparam int RESET_LINE_WIDTH = 4096;
    localparam int RESET_LINE_COUNT = 4096;
    localparam int MIN_LINE         = 3;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_LINE_COUNT = 1'b1
    } cfg_reg_t;

    // position tag that travels with a sample down the pipe
    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [OUT_COL_BITS-1:0] col;
        logic                    last;
    } tag_t;

endpackage

/* design/sps_in_if.sv */
interface sps_in_if #(
    parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

/* design/sps_out_if.sv */
interface sps_out_if #(
    parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     result;
    logic [sps_pkg::ROW_BITS-1:0]      out_row;
    logic [sps_pkg::OUT_COL_BITS-1:0]  out_col;
    logic                              frame_last;

    modport source (output valid, output result, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink (input valid, input result, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

/* design/five_point_stencil_sweep.sv */
// five-point stencil sweep over a raster-order grid. one sample is taken per cycle
// with no gaps needed while results are taken as they come; an output register holds
// a result until it is taken, and a waiting result stalls input once the stages behind
// it are full. the result for interior cell (r-1, c-1) is produced by the transfer of
// sample (r, c), passing the registered read of the line store, the four-neighbor
// sum, then the quarter, the centre subtraction and saturation. border cells give no
// result, so a frame of W x H samples gives (W-2) x (H-2) results, the last one flagged
// with frame_last. the two previous rows live in one MAX_WIDTH deep RAM holding a
// pair of samples per column; its contents need no clearing after reset. writing
// line_width or line_count restarts the frame at row 0, column 0; write only while idle.
// line_width is used clamped to 3..MAX_WIDTH and line_count values below 3 act as 3.
module five_point_stencil_sweep #(
    parameter int MAX_WIDTH   = sps_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sps_in_if.sink                            grid,
    sps_out_if.source                         stencil,
    input  logic                              cfg_write,
    input  logic [0:0]                        cfg_index,
    input  logic [sps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int SB       = SAMPLE_BITS;
    localparam int RST_W    = (sps_pkg::RESET_LINE_WIDTH > MAX_WIDTH) ?
                              MAX_WIDTH : sps_pkg::RESET_LINE_WIDTH;

    // ---------------------------------------------------------------
    // configuration: last column and last row of the frame
    // ---------------------------------------------------------------
    logic [COL_BITS-1:0]          wlast_reg, wlast_next;
    logic [sps_pkg::ROW_BITS-1:0] hlast_reg, hlast_next;
    logic [31:0]                  wreq, weff, hreq, heff;

    always_comb
    begin
        wreq = 32'(cfg_data[sps_pkg::LINE_WIDTH_BITS-1:0]);
        hreq = 32'(cfg_data[sps_pkg::LINE_COUNT_BITS-1:0]);
        priority if (wreq < 32'(sps_pkg::MIN_LINE))
            weff = 32'(sps_pkg::MIN_LINE);
        else if (wreq > 32'(MAX_WIDTH))
            weff = 32'(MAX_WIDTH);
        else
            weff = wreq;
        heff = (hreq < 32'(sps_pkg::MIN_LINE)) ? 32'(sps_pkg::MIN_LINE) : hreq;

        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_write)
        begin
            unique case (sps_pkg::cfg_reg_t'(cfg_index))
                sps_pkg::REG_LINE_WIDTH: wlast_next = COL_BITS'(weff - 32'd1);
                sps_pkg::REG_LINE_COUNT: hlast_next = sps_pkg::ROW_BITS'(heff - 32'd1);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: accept -> stage 1 (ram data) -> stage 2 (sum) -> output
    // ---------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic vo_reg, vo_next;
    logic ready_o, ready2, ready1;
    logic accept, adv1;

    assign ready_o    = !vo_reg || stencil.ready;
    assign ready2     = !v2_reg || ready_o;
    assign ready1     = !v1_reg || ready2;
    assign grid.ready = ready1;
    assign accept     = grid.valid && ready1;
    assign adv1       = v1_reg && ready2;

    // ---------------------------------------------------------------
    // raster position of the next sample
    // ---------------------------------------------------------------
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic [sps_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic                         col_wrap, row_wrap;

    assign col_wrap = (col_reg == wlast_reg);
    assign row_wrap = (row_reg == hlast_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_write)
        begin
            // a register write restarts the frame
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + sps_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    // tag of the cell one row up and one column left of the incoming sample
    logic [31:0]  col_m1_wide;
    sps_pkg::tag_t tag0;
    logic          emit0;

    always_comb
    begin
        col_m1_wide = 32'(col_reg - COL_BITS'(1));
        tag0.row    = row_reg - sps_pkg::ROW_BITS'(1);
        tag0.col    = col_m1_wide[sps_pkg::OUT_COL_BITS-1:0];
        tag0.last   = row_wrap && col_wrap;
        emit0       = (row_reg >= sps_pkg::ROW_BITS'(2)) && (col_reg >= COL_BITS'(2));
    end

    // ---------------------------------------------------------------
    // stage 1: line store read data is valid here
    // ---------------------------------------------------------------
    logic [SB-1:0]       s1_reg;
    logic [COL_BITS-1:0] c1_reg;
    logic                emit1_reg;
    sps_pkg::tag_t       tag1_reg;

    logic [2*SB-1:0] rd_data;
    logic [SB-1:0]   older, newer;

    // each entry holds {row r-2, row r-1} of one column
    sps_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (adv1),
        .waddr (c1_reg),
        .wdata ({newer, s1_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    assign older = rd_data[2*SB-1:SB];
    assign newer = rd_data[SB-1:0];

    // window chain: newer -> centre -> left; up and down load on their own
    logic [SB-1:0] w_ctr, w_left, w_up, w_down;

    sps_cell #(.SAMPLE_BITS(SB)) u_cell_ctr (
        .clk (clk), .rst_n (rst_n), .shift (adv1), .d (newer), .q (w_ctr)
    );
    sps_cell #(.SAMPLE_BITS(SB)) u_cell_left (
        .clk (clk), .rst_n (rst_n), .shift (adv1), .d (w_ctr), .q (w_left)
    );
    sps_cell #(.SAMPLE_BITS(SB)) u_cell_up (
        .clk (clk), .rst_n (rst_n), .shift (adv1), .d (older), .q (w_up)
    );
    sps_cell #(.SAMPLE_BITS(SB)) u_cell_down (
        .clk (clk), .rst_n (rst_n), .shift (adv1), .d (s1_reg), .q (w_down)
    );

    // exact four-neighbor sum, two bits of headroom
    logic signed [SB+1:0] sum1;

    always_comb
    begin
        sum1 = $signed({{2{w_up[SB-1]}}, w_up})
             + $signed({{2{w_down[SB-1]}}, w_down})
             + $signed({{2{w_left[SB-1]}}, w_left})
             + $signed({{2{newer[SB-1]}}, newer});
    end

    // ---------------------------------------------------------------
    // stage 2: quarter, subtract centre, saturate
    // ---------------------------------------------------------------
    logic signed [SB+1:0] sum2_reg;
    logic [SB-1:0]        ctr2_reg;
    sps_pkg::tag_t        tag2_reg;

    logic signed [SB-1:0] quarter;
    logic signed [SB:0]   diff;
    logic [SB-1:0]        sat;

    always_comb
    begin
        quarter = sum2_reg[SB+1:2];   // floor of sum / 4
        diff    = $signed({quarter[SB-1], quarter}) - $signed({ctr2_reg[SB-1], ctr2_reg});
        priority if (diff[SB] != diff[SB-1])
            sat = diff[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        else
            sat = diff[SB-1:0];
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [SB-1:0] res_reg;
    sps_pkg::tag_t tago_reg;

    always_comb
    begin
        v1_next = ready1 ? grid.valid : v1_reg;
        v2_next = ready2 ? (v1_reg && emit1_reg) : v2_reg;
        vo_next = ready_o ? v2_reg : vo_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= COL_BITS'(RST_W - 1);
            hlast_reg <= sps_pkg::ROW_BITS'(sps_pkg::RESET_LINE_COUNT - 1);
            col_reg   <= '0;
            row_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vo_reg    <= 1'b0;
        end
        else
        begin
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            vo_reg    <= vo_next;
        end
    end

    // payload, loaded on each stage transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= grid.sample;
            c1_reg    <= col_reg;
            emit1_reg <= emit0;
            tag1_reg  <= tag0;
        end
        if (adv1)
        begin
            sum2_reg <= sum1;
            ctr2_reg <= w_ctr;
            tag2_reg <= tag1_reg;
        end
        if (ready_o && v2_reg)
        begin
            res_reg  <= sat;
            tago_reg <= tag2_reg;
        end
    end

    assign stencil.valid      = vo_reg;
    assign stencil.result     = res_reg;
    assign stencil.out_row    = tago_reg.row;
    assign stencil.out_col    = tago_reg.col;
    assign stencil.frame_last = tago_reg.last;

`ifndef SYNTH
    // raster counters never run past the configured frame
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wlast_reg)
        else $error("column counter beyond line width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= hlast_reg)
        else $error("row counter beyond line count");

    // line store data must hold while stage 1 is stalled
    a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv1) |=> $stable(rd_data))
        else $error("line store read data changed under a stalled stage");

    // a result only comes from an interior cell, never row zero
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (tag2_reg.row != '0))
        else $error("result produced for a border row");
`endif
endmodule

/* design/sps_ram.sv */
module sps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* design/sps_cell.sv */
// one window tap: loads from its neighbor when the window shifts
module sps_cell #(
    parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic [SAMPLE_BITS-1:0] d,
    output logic [SAMPLE_BITS-1:0] q
);
    logic [SAMPLE_BITS-1:0] tap_reg;
    logic [SAMPLE_BITS-1:0] tap_next;

    always_comb
    begin
        tap_next = shift ? d : tap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    assign q = tap_reg;
endmodule
